// ===== hdl/kseq_pkg.sv =====
`timescale 1ns / 1ps

package kseq_pkg;

  // parser phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_ESC     = 3'd1;
  localparam logic [2:0] PH_BRACKET = 3'd2;
  localparam logic [2:0] PH_ARG0    = 3'd3;
  localparam logic [2:0] PH_SEMI    = 3'd4;
  localparam logic [2:0] PH_ARG1    = 3'd5;

  // key kind codes
  localparam logic [3:0] KIND_NONE      = 4'd0;
  localparam logic [3:0] KIND_CHAR      = 4'd1;
  localparam logic [3:0] KIND_ENTER     = 4'd2;
  localparam logic [3:0] KIND_BACKSPACE = 4'd3;
  localparam logic [3:0] KIND_TAB       = 4'd4;
  localparam logic [3:0] KIND_LEFT      = 4'd5;
  localparam logic [3:0] KIND_RIGHT     = 4'd6;
  localparam logic [3:0] KIND_UP        = 4'd7;
  localparam logic [3:0] KIND_DOWN      = 4'd8;
  localparam logic [3:0] KIND_DELETE    = 4'd9;
  localparam logic [3:0] KIND_BACKTAB   = 4'd10;

  // special bytes
  localparam logic [7:0] CH_CTRL_Q = 8'd17;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_DEL    = 8'd127;
  localparam logic [7:0] CH_BS     = 8'd8;
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_CTRL_S = 8'd19;
  localparam logic [7:0] CH_ESC    = 8'd27;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_Q  = 8'h71;
  localparam logic [7:0] CH_LOW_S  = 8'h73;

  // modifier values
  localparam logic [7:0] MOD_CTRL = 8'd5;
  localparam logic [7:0] MOD_ALT  = 8'd3;

  // digits allowed in one number
  localparam logic [1:0] MAX_ARG_DIGITS = 2'd3;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] digit_count;
    logic [7:0] modifier;
  } kseq_state_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] chr;
    logic       ctrl;
    logic       alt;
  } kseq_key_t;

endpackage

// ===== hdl/kseq_if.sv =====
`timescale 1ns / 1ps

// byte request channel
interface kseq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// key event request channel
interface kseq_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] key_kind;
  logic [7:0] key_code;
  logic       ctrl_mod;
  logic       alt_mod;

  modport source (output valid, output key_kind, output key_code, output ctrl_mod,
                  output alt_mod, input ready);
  modport sink (input valid, input key_kind, input key_code, input ctrl_mod,
                input alt_mod, output ready);
endinterface

// ===== hdl/kseq_decode.sv =====
`timescale 1ns / 1ps

module kseq_decode
  import kseq_pkg::*;
#(
  parameter logic [1:0] MAX_DIGITS = MAX_ARG_DIGITS
) (
  input  kseq_state_t state_i,
  input  logic [7:0]  byte_i,
  output kseq_state_t state_o,
  output kseq_key_t   key_o,
  output logic        key_vld_o
);

  logic       is_digit;
  logic [7:0] digit_val;
  logic       mod_ctrl;
  logic       mod_alt;
  kseq_key_t  final_key;
  kseq_key_t  plain_key;

  assign is_digit  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign digit_val = byte_i - CH_ZERO;
  assign mod_ctrl  = (state_i.modifier == MOD_CTRL);
  assign mod_alt   = (state_i.modifier == MOD_ALT);

  // final byte of a sequence
  always_comb begin
    final_key = '0;
    case (byte_i)
      "D": begin
        final_key = '{kind: KIND_LEFT, chr: 8'd0, ctrl: mod_ctrl, alt: mod_alt};
      end
      "C": begin
        final_key = '{kind: KIND_RIGHT, chr: 8'd0, ctrl: mod_ctrl, alt: mod_alt};
      end
      "A": begin
        final_key = '{kind: KIND_UP, chr: 8'd0, ctrl: mod_ctrl, alt: mod_alt};
      end
      "B": begin
        final_key = '{kind: KIND_DOWN, chr: 8'd0, ctrl: mod_ctrl, alt: mod_alt};
      end
      "~", "P": begin
        final_key = '{kind: KIND_DELETE, chr: 8'd0, ctrl: mod_ctrl, alt: mod_alt};
      end
      "M": begin
        // delete with ctrl always on
        final_key = '{kind: KIND_DELETE, chr: 8'd0, ctrl: 1'b1, alt: mod_alt};
      end
      "Z": begin
        final_key = '{kind: KIND_BACKTAB, chr: 8'd0, ctrl: mod_ctrl, alt: mod_alt};
      end
      default: begin
        final_key = '0;
      end
    endcase
  end

  // byte outside a sequence
  always_comb begin
    plain_key = '0;
    case (byte_i)
      CH_CTRL_Q: plain_key = '{kind: KIND_CHAR, chr: CH_LOW_Q, ctrl: 1'b1, alt: 1'b0};
      CH_CR:     plain_key = '{kind: KIND_ENTER, chr: 8'd0, ctrl: 1'b0, alt: 1'b0};
      CH_DEL:    plain_key = '{kind: KIND_BACKSPACE, chr: 8'd0, ctrl: 1'b0, alt: 1'b0};
      CH_BS:     plain_key = '{kind: KIND_BACKSPACE, chr: 8'd0, ctrl: 1'b1, alt: 1'b0};
      CH_TAB:    plain_key = '{kind: KIND_TAB, chr: 8'd0, ctrl: 1'b0, alt: 1'b0};
      CH_CTRL_S: plain_key = '{kind: KIND_CHAR, chr: CH_LOW_S, ctrl: 1'b1, alt: 1'b0};
      default:   plain_key = '{kind: KIND_CHAR, chr: byte_i, ctrl: 1'b0, alt: 1'b0};
    endcase
  end

  // phase transitions
  always_comb begin
    state_o   = state_i;
    key_o     = '0;
    key_vld_o = 1'b0;
    case (state_i.phase)
      PH_ESC: begin
        if (byte_i != CH_LBRACK) begin
          state_o   = '{phase: PH_IDLE, digit_count: 2'd0, modifier: 8'd0};
          key_vld_o = 1'b1;
        end else begin
          state_o = '{phase: PH_BRACKET, digit_count: 2'd0, modifier: 8'd0};
        end
      end
      PH_BRACKET: begin
        if (is_digit) begin
          state_o.phase       = PH_ARG0;
          state_o.digit_count = 2'd1;
        end else if (byte_i == CH_SEMI) begin
          state_o.phase = PH_SEMI;
        end else begin
          state_o   = '{phase: PH_IDLE, digit_count: 2'd0, modifier: 8'd0};
          key_o     = final_key;
          key_vld_o = 1'b1;
        end
      end
      PH_ARG0: begin
        if (is_digit) begin
          if (state_i.digit_count >= MAX_DIGITS) begin
            state_o   = '{phase: PH_IDLE, digit_count: 2'd0, modifier: 8'd0};
            key_vld_o = 1'b1;
          end else begin
            state_o.digit_count = state_i.digit_count + 2'd1;
          end
        end else if (byte_i == CH_SEMI) begin
          state_o.phase       = PH_SEMI;
          state_o.digit_count = 2'd0;
        end else begin
          state_o   = '{phase: PH_IDLE, digit_count: 2'd0, modifier: 8'd0};
          key_o     = final_key;
          key_vld_o = 1'b1;
        end
      end
      PH_SEMI: begin
        if (is_digit) begin
          state_o = '{phase: PH_ARG1, digit_count: 2'd1, modifier: digit_val};
        end else begin
          state_o   = '{phase: PH_IDLE, digit_count: 2'd0, modifier: 8'd0};
          key_o     = final_key;
          key_vld_o = 1'b1;
        end
      end
      PH_ARG1: begin
        if (is_digit) begin
          if (state_i.digit_count >= MAX_DIGITS) begin
            state_o   = '{phase: PH_IDLE, digit_count: 2'd0, modifier: 8'd0};
            key_vld_o = 1'b1;
          end else begin
            // modifier times ten plus digit, wrapping at 8 bits
            state_o.digit_count = state_i.digit_count + 2'd1;
            state_o.modifier    = {state_i.modifier[4:0], 3'b000}
                                + {state_i.modifier[6:0], 1'b0} + digit_val;
          end
        end else begin
          state_o   = '{phase: PH_IDLE, digit_count: 2'd0, modifier: 8'd0};
          key_o     = final_key;
          key_vld_o = 1'b1;
        end
      end
      default: begin
        // idle and unused codes
        if (byte_i == CH_ESC) begin
          state_o = '{phase: PH_ESC, digit_count: 2'd0, modifier: 8'd0};
        end else begin
          state_o.phase = PH_IDLE;
          key_o         = plain_key;
          key_vld_o     = 1'b1;
        end
      end
    endcase
  end

endmodule

// ===== hdl/terminal_key_sequence_decoder.sv =====
`timescale 1ns / 1ps

// a key event is valid in the cycle after the byte request that ends it is accepted
// one byte per cycle while the single output register is free or being drained; bytes stall otherwise
// a new byte is taken while a waiting event is being taken downstream
// reset: parser returns to idle with digit count and modifier cleared,
// and the output register is emptied
module terminal_key_sequence_decoder
  import kseq_pkg::*;
#(
  parameter logic [1:0] MAX_DIGITS = MAX_ARG_DIGITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kseq_in_if.sink     in_i,
  kseq_out_if.source  out_o
);

  kseq_state_t state_q;
  kseq_state_t state_d;
  kseq_key_t   key_d;
  kseq_key_t   key_q;
  logic        key_vld;
  logic        out_valid_q;
  logic        in_accept;

  // take a byte whenever the output slot is free or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_accept  = in_i.valid && in_i.ready;

  kseq_decode #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_decode (
    .state_i   (state_q),
    .byte_i    (in_i.in_byte),
    .state_o   (state_d),
    .key_o     (key_d),
    .key_vld_o (key_vld)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_IDLE, digit_count: 2'd0, modifier: 8'd0};
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept && key_vld) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (in_accept && key_vld) begin
      key_q <= key_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.key_kind = key_q.kind;
  assign out_o.key_code = key_q.chr;
  assign out_o.ctrl_mod = key_q.ctrl;
  assign out_o.alt_mod  = key_q.alt;

endmodule
